// ----- sv/voipm_pkg.sv -----
// ============================================================================
// voipm_pkg: shared types, constants and microcode for the VoIP metrics block
// Holds the control word layout, the sequencer program and the codes that
// the sequencer and the datapath exchange.
// ============================================================================
package voipm_pkg;

    localparam int StepW    = 4;
    localparam int DivW     = 32;
    localparam int DivCntW  = 5;
    localparam int RttDivisor = 1000;

    // x / 1000 for any 32-bit x: multiply by ceil(2^38 / 1000), drop 38 bits
    localparam logic [28:0] RttRecip = 29'd274877907;
    localparam int          RttShift = 38;

    localparam logic [7:0] FrameMsReset   = 8'd20;
    localparam logic [4:0] FramesPktReset = 5'd1;
    localparam logic [9:0] ExtraDlyReset  = 10'd30;

    typedef enum logic [1:0] {
        CFG_FRAME_MS      = 2'd0,
        CFG_FRAMES_PKT    = 2'd1,
        CFG_EXTRA_DELAY   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_PREP,
        OP_MUL,
        OP_DIV,
        OP_JNR,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        NUM_C23_SH16,
        NUM_C14_SH8,
        NUM_P23_SH8,
        NUM_PROD,
        NUM_LOST_SH8,
        NUM_DISC_SH8,
        NUM_RTT
    } num_sel_t;

    typedef enum logic [2:0] {
        DEN_DEN3,
        DEN_C22_C23,
        DEN_C11_C14,
        DEN_P23_P32,
        DEN_C13ADJ,
        DEN_TOTAL,
        DEN_K1000
    } den_sel_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_P32,
        DST_P23,
        DST_GDEN,
        DST_BDEN,
        DST_GDUR,
        DST_BDUR,
        DST_LRATE,
        DST_DRATE,
        DST_RTT
    } dst_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_WAIT
    } seq_state_t;

    typedef struct packed {
        op_t              op;
        num_sel_t         num;
        den_sel_t         den;
        dst_t             dst;
        logic             mul_burst;
        logic [StepW-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic     capture;
        logic     prep;
        logic     mul_en;
        logic     mul_burst;
        logic     div_start;
        num_sel_t num;
        den_sel_t den;
        logic     wr_en;
        dst_t     dst;
        logic     finish;
    } dp_ctl_t;

    typedef struct packed {
        logic div_done;
        logic rtt_none;
    } dp_stat_t;

    typedef struct packed {
        logic [7:0]  loss_fraction;
        logic [7:0]  discard_fraction;
        logic [7:0]  burst_density;
        logic [7:0]  gap_density;
        logic [15:0] burst_duration_ms;
        logic [15:0] gap_duration_ms;
        logic [15:0] round_trip_ms;
        logic [15:0] end_system_delay_ms;
    } res_t;

    localparam logic [StepW-1:0] StepEnd = 4'd13;

    function automatic ucode_t uc(input op_t op, input num_sel_t num,
                                  input den_sel_t den, input dst_t dst,
                                  input logic mul_burst,
                                  input logic [StepW-1:0] target);
        ucode_t w;
        w.op        = op;
        w.num       = num;
        w.den       = den;
        w.dst       = dst;
        w.mul_burst = mul_burst;
        w.target    = target;
        return w;
    endfunction

    // Program: derive sums, transition probabilities, densities,
    // durations, rates, then the round trip when an estimate is present.
    function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
        ucode_t w;
        case (step)
            4'd0:    w = uc(OP_PREP, NUM_RTT, DEN_K1000, DST_NONE, 1'b0, 4'd0);
            4'd1:    w = uc(OP_DIV, NUM_C23_SH16, DEN_DEN3, DST_P32, 1'b0, 4'd0);
            4'd2:    w = uc(OP_DIV, NUM_C23_SH16, DEN_C22_C23, DST_P23, 1'b0, 4'd0);
            4'd3:    w = uc(OP_DIV, NUM_C14_SH8, DEN_C11_C14, DST_GDEN, 1'b0, 4'd0);
            4'd4:    w = uc(OP_DIV, NUM_P23_SH8, DEN_P23_P32, DST_BDEN, 1'b0, 4'd0);
            4'd5:    w = uc(OP_MUL, NUM_PROD, DEN_C13ADJ, DST_NONE, 1'b0, 4'd0);
            4'd6:    w = uc(OP_DIV, NUM_PROD, DEN_C13ADJ, DST_GDUR, 1'b0, 4'd0);
            4'd7:    w = uc(OP_MUL, NUM_PROD, DEN_C13ADJ, DST_NONE, 1'b1, 4'd0);
            4'd8:    w = uc(OP_DIV, NUM_PROD, DEN_C13ADJ, DST_BDUR, 1'b0, 4'd0);
            4'd9:    w = uc(OP_DIV, NUM_LOST_SH8, DEN_TOTAL, DST_LRATE, 1'b0, 4'd0);
            4'd10:   w = uc(OP_DIV, NUM_DISC_SH8, DEN_TOTAL, DST_DRATE, 1'b0, 4'd0);
            4'd11:   w = uc(OP_JNR, NUM_RTT, DEN_K1000, DST_NONE, 1'b0, StepEnd);
            4'd12:   w = uc(OP_MUL, NUM_RTT, DEN_K1000, DST_RTT, 1'b0, 4'd0);
            default: w = uc(OP_END, NUM_RTT, DEN_K1000, DST_NONE, 1'b0, 4'd0);
        endcase
        return w;
    endfunction

endpackage

// ----- sv/voipm_div.sv -----
// ============================================================================
// voipm_div: radix-2 restoring divider
// One quotient bit per cycle; a zero divisor yields a zero quotient.
// ============================================================================
module voipm_div
    import voipm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DivW-1:0] dividend,
    input  logic [DivW-1:0] divisor,
    output logic            done,
    output logic [DivW-1:0] quotient
);

    logic               run_reg;
    logic               run_next;
    logic               done_reg;
    logic               done_next;
    logic [DivCntW-1:0] cnt_reg;
    logic [DivCntW-1:0] cnt_next;
    logic [DivW-1:0]    rem_reg;
    logic [DivW-1:0]    quo_reg;
    logic [DivW-1:0]    den_reg;
    logic               dz_reg;
    logic [DivW:0]      shifted;
    logic [DivW:0]      diff;

    assign shifted = {rem_reg, quo_reg[DivW-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DivCntW'(DivW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
            dz_reg  <= (divisor == '0);
        end
        else if (run_reg)
        begin
            // keep the partial remainder when the trial subtract goes negative
            if (!diff[DivW])
            begin
                rem_reg <= diff[DivW-1:0];
            end
            else
            begin
                rem_reg <= shifted[DivW-1:0];
            end
            quo_reg <= {quo_reg[DivW-2:0], ~diff[DivW]};
        end
    end

    assign done     = done_reg;
    assign quotient = dz_reg ? '0 : quo_reg;

endmodule

// ----- sv/voipm_seq.sv -----
// ============================================================================
// voipm_seq: microcode sequencer
// Steps through the control program, issues divider runs and waits on them.
// ============================================================================
module voipm_seq
    import voipm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctl_t  ctl,
    output logic     busy,
    output logic     done
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [StepW-1:0] step_reg;
    logic [StepW-1:0] step_next;
    logic             strobe_reg;
    logic             strobe_next;
    ucode_t           word;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SQ_RUN;
                    step_next  = '0;
                end
            end
            SQ_RUN:
            begin
                case (word.op)
                    OP_PREP, OP_MUL:
                    begin
                        step_next = step_reg + 1'b1;
                    end
                    OP_DIV:
                    begin
                        state_next = SQ_WAIT;
                    end
                    OP_JNR:
                    begin
                        step_next = stat.rtt_none ? word.target : step_reg + 1'b1;
                    end
                    default:
                    begin
                        state_next = SQ_IDLE;
                    end
                endcase
            end
            SQ_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = SQ_RUN;
                    step_next  = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.num       = word.num;
        ctl.den       = word.den;
        ctl.dst       = word.dst;
        ctl.mul_burst = word.mul_burst;
        strobe_next   = 1'b0;
        case (state_reg)
            SQ_IDLE:
            begin
                ctl.capture = start;
            end
            SQ_RUN:
            begin
                ctl.prep      = (word.op == OP_PREP);
                ctl.mul_en    = (word.op == OP_MUL);
                ctl.div_start = (word.op == OP_DIV);
                ctl.finish    = (word.op == OP_END);
                strobe_next   = (word.op == OP_END);
            end
            SQ_WAIT:
            begin
                ctl.wr_en = stat.div_done;
            end
            default:
            begin
                ctl.capture = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SQ_IDLE;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy = (state_reg != SQ_IDLE);
    assign done = strobe_reg;

endmodule

// ----- sv/voipm_dp.sv -----
// ============================================================================
// voipm_dp: metrics datapath
// Operand registers, packet-time multiplier, shared divider and result
// registers, all driven by the sequencer's control word.
// ============================================================================
module voipm_dp
    import voipm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_ctl_t     ctl,
    input  logic [15:0] count_gap_gap,
    input  logic [15:0] count_gap_burst_loss,
    input  logic [15:0] count_gap_isolated,
    input  logic [15:0] count_burst_stay,
    input  logic [15:0] count_burst_to_loss,
    input  logic [15:0] count_loss_loss,
    input  logic [15:0] lost_packets,
    input  logic [15:0] discarded_packets,
    input  logic [31:0] rtt_xr_us,
    input  logic [31:0] rtt_base_us,
    input  logic [15:0] jitter_nominal_ms,
    input  logic [7:0]  frame_ms,
    input  logic [4:0]  pkt_frames,
    input  logic [9:0]  extra_delay_ms,
    output dp_stat_t    stat,
    output res_t        res
);

    logic [15:0] c11_reg, c13_reg, c14_reg, c22_reg, c23_reg, c33_reg;
    logic [15:0] lost_reg, disc_reg, jb_reg;
    logic [31:0] rtt_reg;
    logic        rtt_none_reg;

    logic        total_zero_reg;
    logic [18:0] total_reg;
    logic [15:0] c13adj_reg;
    logic [17:0] gapsum_reg;
    logic [18:0] burst_reg;
    logic [17:0] den3_reg;
    logic [16:0] c22c23_reg;
    logic [16:0] c11c14_reg;
    logic [12:0] m_reg;
    logic [31:0] prod_reg;

    logic [16:0] p32_reg, p23_reg;
    logic [7:0]  gden_reg, bden_reg, lrate_reg, drate_reg;
    logic [15:0] gdur_reg, bdur_reg;
    logic [15:0] held_reg;
    res_t        res_reg;

    logic        c13_zero;
    logic [18:0] mul_a;
    logic [60:0] rtt_prod;
    logic [31:0] num_val;
    logic [31:0] den_val;
    logic        div_done;
    logic [31:0] quot;

    assign c13_zero = (c13_reg == 16'd0);
    assign mul_a    = ctl.mul_burst ? burst_reg : {1'b0, gapsum_reg};
    assign rtt_prod = {29'd0, rtt_reg} * {32'd0, RttRecip};

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            c11_reg      <= count_gap_gap;
            c13_reg      <= count_gap_burst_loss;
            c14_reg      <= count_gap_isolated;
            c22_reg      <= count_burst_stay;
            c23_reg      <= count_burst_to_loss;
            c33_reg      <= count_loss_loss;
            lost_reg     <= lost_packets;
            disc_reg     <= discarded_packets;
            jb_reg       <= jitter_nominal_ms;
            rtt_reg      <= (rtt_xr_us != 32'd0) ? rtt_xr_us : rtt_base_us;
            rtt_none_reg <= (rtt_xr_us == 32'd0) && (rtt_base_us == 32'd0);
        end
        if (ctl.prep)
        begin
            // c31 and c32 mirror c13 and c23; a zero c13 counts as one
            total_zero_reg <= (c11_reg == 16'd0) && c13_zero && (c14_reg == 16'd0)
                              && (c22_reg == 16'd0) && (c23_reg == 16'd0)
                              && (c33_reg == 16'd0);
            total_reg  <= 19'(c11_reg) + 19'(c14_reg) + 19'(c13_reg) + 19'(c22_reg)
                          + 19'(c23_reg) + 19'(c13_reg) + 19'(c23_reg) + 19'(c33_reg)
                          + 19'(c13_zero);
            c13adj_reg <= c13_zero ? 16'd1 : c13_reg;
            gapsum_reg <= 18'(c11_reg) + 18'(c14_reg) + 18'(c13_reg) + 18'(c13_zero);
            burst_reg  <= 19'(c22_reg) + {2'd0, c23_reg, 1'b0} + 19'(c13_reg)
                          + 19'(c33_reg);
            den3_reg   <= 18'(c13_reg) + 18'(c23_reg) + 18'(c33_reg);
            c22c23_reg <= 17'(c22_reg) + 17'(c23_reg);
            c11c14_reg <= 17'(c11_reg) + 17'(c14_reg);
            m_reg      <= {5'd0, frame_ms} * {8'd0, pkt_frames};
        end
        if (ctl.mul_en && (ctl.dst != DST_RTT))
        begin
            prod_reg <= {13'd0, mul_a} * {19'd0, m_reg};
        end
        if (ctl.wr_en)
        begin
            case (ctl.dst)
                DST_P32:   p32_reg   <= quot[16:0];
                DST_P23:   p23_reg   <= quot[16:0];
                DST_GDEN:  gden_reg  <= quot[7:0];
                DST_BDEN:  bden_reg  <= quot[7:0];
                DST_GDUR:  gdur_reg  <= quot[15:0];
                DST_BDUR:  bdur_reg  <= quot[15:0];
                DST_LRATE: lrate_reg <= quot[7:0];
                DST_DRATE: drate_reg <= quot[7:0];
                default:   p32_reg   <= p32_reg;
            endcase
        end
        if (ctl.finish)
        begin
            // all-zero counts force the six ratio fields to zero
            res_reg.loss_fraction       <= total_zero_reg ? 8'd0 : lrate_reg;
            res_reg.discard_fraction    <= total_zero_reg ? 8'd0 : drate_reg;
            res_reg.burst_density       <= total_zero_reg ? 8'd0 : bden_reg;
            res_reg.gap_density         <= total_zero_reg ? 8'd0 : gden_reg;
            res_reg.burst_duration_ms   <= total_zero_reg ? 16'd0 : bdur_reg;
            res_reg.gap_duration_ms     <= total_zero_reg ? 16'd0 : gdur_reg;
            res_reg.round_trip_ms       <= held_reg;
            res_reg.end_system_delay_ms <= {1'b0, held_reg[15:1]} + jb_reg
                                           + {6'd0, extra_delay_ms};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'd0;
        end
        else if (ctl.mul_en && (ctl.dst == DST_RTT))
        begin
            held_reg <= rtt_prod[RttShift+15:RttShift];
        end
    end

    always_comb
    begin
        case (ctl.num)
            NUM_C23_SH16: num_val = {c23_reg, 16'd0};
            NUM_C14_SH8:  num_val = {8'd0, c14_reg, 8'd0};
            NUM_P23_SH8:  num_val = {7'd0, p23_reg, 8'd0};
            NUM_PROD:     num_val = prod_reg;
            NUM_LOST_SH8: num_val = {8'd0, lost_reg, 8'd0};
            NUM_DISC_SH8: num_val = {8'd0, disc_reg, 8'd0};
            NUM_RTT:      num_val = rtt_reg;
            default:      num_val = 32'd0;
        endcase
    end

    always_comb
    begin
        case (ctl.den)
            DEN_DEN3:    den_val = {14'd0, den3_reg};
            DEN_C22_C23: den_val = {15'd0, c22c23_reg};
            DEN_C11_C14: den_val = {15'd0, c11c14_reg};
            DEN_P23_P32: den_val = {15'd0, p23_reg} + {15'd0, p32_reg};
            DEN_C13ADJ:  den_val = {16'd0, c13adj_reg};
            DEN_TOTAL:   den_val = {13'd0, total_reg};
            DEN_K1000:   den_val = 32'(RttDivisor);
            default:     den_val = 32'd0;
        endcase
    end

    voipm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (num_val),
        .divisor  (den_val),
        .done     (div_done),
        .quotient (quot)
    );

    assign stat.div_done = div_done;
    assign stat.rtt_none = rtt_none_reg;
    assign res           = res_reg;

endmodule

// ----- sv/voip_burst_gap_metrics_top.sv -----
// ============================================================================
// voip_burst_gap_metrics_top: VoIP metrics report values
// Turns one snapshot of loss-state transition counts into loss and discard
// rates, burst and gap densities and durations, round trip and end-system
// delay.
// ============================================================================
// Pulse start while busy is low to transfer one snapshot. busy stays high
// until the results are ready; done then pulses for exactly one cycle with
// all eight result fields valid in that cycle, so sample them there; the
// fields then hold until the next computation ends. A new start is taken
// in the done cycle; the round-trip step runs only when either round-trip
// estimate is nonzero. The eight divisions run in turn on the single shared
// radix-2 divider, and the round trip takes one reciprocal-multiply step.
// Register writes are taken at any time with cfg_ready always high; write
// them only while busy is low.
module voip_burst_gap_metrics_top
    import voipm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] count_gap_gap,
    input  logic [15:0] count_gap_burst_loss,
    input  logic [15:0] count_gap_isolated,
    input  logic [15:0] count_burst_stay,
    input  logic [15:0] count_burst_to_loss,
    input  logic [15:0] count_loss_loss,
    input  logic [15:0] lost_packets,
    input  logic [15:0] discarded_packets,
    input  logic [31:0] rtt_xr_us,
    input  logic [31:0] rtt_base_us,
    input  logic [15:0] jitter_nominal_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output logic        done,
    output logic [7:0]  loss_fraction,
    output logic [7:0]  discard_fraction,
    output logic [7:0]  burst_density,
    output logic [7:0]  gap_density,
    output logic [15:0] burst_duration_ms,
    output logic [15:0] gap_duration_ms,
    output logic [15:0] round_trip_ms,
    output logic [15:0] end_system_delay_ms
);

    logic [7:0] frame_reg;
    logic [4:0] fpp_reg;
    logic [9:0] extra_reg;
    dp_ctl_t    ctl;
    dp_stat_t   stat;
    res_t       res;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= FrameMsReset;
            fpp_reg   <= FramesPktReset;
            extra_reg <= ExtraDlyReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_MS:    frame_reg <= cfg_data[7:0];
                CFG_FRAMES_PKT:  fpp_reg   <= cfg_data[4:0];
                CFG_EXTRA_DELAY: extra_reg <= cfg_data;
                default:         extra_reg <= extra_reg;
            endcase
        end
    end

    voipm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    voipm_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctl                  (ctl),
        .count_gap_gap        (count_gap_gap),
        .count_gap_burst_loss (count_gap_burst_loss),
        .count_gap_isolated   (count_gap_isolated),
        .count_burst_stay     (count_burst_stay),
        .count_burst_to_loss  (count_burst_to_loss),
        .count_loss_loss      (count_loss_loss),
        .lost_packets         (lost_packets),
        .discarded_packets    (discarded_packets),
        .rtt_xr_us            (rtt_xr_us),
        .rtt_base_us          (rtt_base_us),
        .jitter_nominal_ms    (jitter_nominal_ms),
        .frame_ms             (frame_reg),
        .pkt_frames           (fpp_reg),
        .extra_delay_ms       (extra_reg),
        .stat                 (stat),
        .res                  (res)
    );

    assign loss_fraction       = res.loss_fraction;
    assign discard_fraction    = res.discard_fraction;
    assign burst_density       = res.burst_density;
    assign gap_density         = res.gap_density;
    assign burst_duration_ms   = res.burst_duration_ms;
    assign gap_duration_ms     = res.gap_duration_ms;
    assign round_trip_ms       = res.round_trip_ms;
    assign end_system_delay_ms = res.end_system_delay_ms;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done strobe outside the end of a computation");

    a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_start || ctl.wr_en || ctl.prep) |-> busy)
        else $error("datapath control active while idle");

    a_div_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |=> !ctl.div_start && !stat.div_done)
        else $error("divider restarted or finished too early");

endmodule

// ----- bench/tb_voip_burst_gap_metrics_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_voip_burst_gap_metrics_top: self-checking bench for the VoIP metrics block
// Feeds loss-statistics snapshots through the start/busy handshake, predicts
// each report from a bit-exact model of the metric arithmetic and compares
// every done strobe field by field. The packet-time and delay registers are
// swept between phases while the block is idle.
// ============================================================================
module tb_voip_burst_gap_metrics_top;
    import voipm_pkg::*;

    localparam int PhaseCount = 10;
    localparam int PhaseItems = 73;
    localparam int TailCycles = 350;
    localparam int CycleLimit = 2_500_000;

    typedef struct {
        logic [15:0] c11;
        logic [15:0] c13;
        logic [15:0] c14;
        logic [15:0] c22;
        logic [15:0] c23;
        logic [15:0] c33;
        logic [15:0] lost;
        logic [15:0] disc;
        logic [31:0] rtt_xr;
        logic [31:0] rtt_base;
        logic [15:0] jitter;
    } snapshot_t;

    class report_tracker;
        res_t         expected_reports[$];
        logic [7:0]   frame_len;
        logic [4:0]   frames_pkt;
        logic [9:0]   extra_dly;
        logic [15:0]  held_rtt;
        int unsigned  mismatches;
        int unsigned  reports_checked;
        int unsigned  snapshots_taken;

        function new();
            frame_len  = FrameMsReset;
            frames_pkt = FramesPktReset;
            extra_dly  = ExtraDlyReset;
            held_rtt   = '0;
            mismatches = 0;
            reports_checked = 0;
            snapshots_taken = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [9:0] value);
            case (idx)
                CFG_FRAME_MS:    frame_len  = value[7:0];
                CFG_FRAMES_PKT:  frames_pkt = value[4:0];
                CFG_EXTRA_DELAY: extra_dly  = value;
                default: ;
            endcase
        endfunction

        function res_t predict_report(snapshot_t s);
            bit [31:0] c11, c13, c14, c22, c23, c33;
            bit [31:0] m, total, den3, p32, p23, gapsum, tmp;
            res_t r;
            c11 = 32'(s.c11);
            c13 = 32'(s.c13);
            c14 = 32'(s.c14);
            c22 = 32'(s.c22);
            c23 = 32'(s.c23);
            c33 = 32'(s.c33);
            m = 32'(frame_len) * 32'(frames_pkt);
            // c31 mirrors c13 and c32 mirrors c23
            total = c11 + c14 + c13 + c22 + c23 + c13 + c23 + c33;
            r = '0;
            if (total != 0) begin
                den3 = c13 + c23 + c33;
                p32 = (den3 == 0) ? 32'd0 : (c23 << 16) / den3;
                p23 = (c23 == 0) ? 32'd0 : (c23 << 16) / (c22 + c23);
                if (c11 != 0) begin
                    tmp = (c14 << 8) / (c11 + c14);
                    r.gap_density = tmp[7:0];
                end
                if (p23 != 0) begin
                    tmp = (p23 << 8) / (p23 + p32);
                    r.burst_density = tmp[7:0];
                end
                // no gap-to-burst transitions: count one and widen the total
                if (c13 == 0) begin
                    c13 = 1;
                    total = total + 1;
                end
                gapsum = c11 + c14 + c13;
                tmp = (gapsum * m) / c13;
                r.gap_duration_ms = tmp[15:0];
                tmp = ((total - gapsum) * m) / c13;
                r.burst_duration_ms = tmp[15:0];
                tmp = (32'(s.lost) << 8) / total;
                r.loss_fraction = tmp[7:0];
                tmp = (32'(s.disc) << 8) / total;
                r.discard_fraction = tmp[7:0];
            end
            // first nonzero estimate wins; none at all holds the last value
            if (s.rtt_xr != 0) begin
                tmp = s.rtt_xr / RttDivisor;
                held_rtt = tmp[15:0];
            end else if (s.rtt_base != 0) begin
                tmp = s.rtt_base / RttDivisor;
                held_rtt = tmp[15:0];
            end
            r.round_trip_ms = held_rtt;
            tmp = 32'(held_rtt) / 2 + 32'(s.jitter) + 32'(extra_dly);
            r.end_system_delay_ms = tmp[15:0];
            return r;
        endfunction

        function void note_snapshot(snapshot_t s);
            expected_reports.push_back(predict_report(s));
            snapshots_taken++;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d want %0d (report %0d)",
                                          name, got, want, reports_checked));
        endtask

        task check_report(res_t got);
            res_t want;
            if (expected_reports.size() == 0) begin
                report_mismatch("done strobe with no snapshot outstanding");
            end else begin
                want = expected_reports.pop_front();
                compare_field("loss_fraction", 16'(got.loss_fraction),
                              16'(want.loss_fraction));
                compare_field("discard_fraction", 16'(got.discard_fraction),
                              16'(want.discard_fraction));
                compare_field("burst_density", 16'(got.burst_density),
                              16'(want.burst_density));
                compare_field("gap_density", 16'(got.gap_density),
                              16'(want.gap_density));
                compare_field("burst_duration_ms", got.burst_duration_ms,
                              want.burst_duration_ms);
                compare_field("gap_duration_ms", got.gap_duration_ms,
                              want.gap_duration_ms);
                compare_field("round_trip_ms", got.round_trip_ms, want.round_trip_ms);
                compare_field("end_system_delay_ms", got.end_system_delay_ms,
                              want.end_system_delay_ms);
            end
            reports_checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] count_gap_gap;
    logic [15:0] count_gap_burst_loss;
    logic [15:0] count_gap_isolated;
    logic [15:0] count_burst_stay;
    logic [15:0] count_burst_to_loss;
    logic [15:0] count_loss_loss;
    logic [15:0] lost_packets;
    logic [15:0] discarded_packets;
    logic [31:0] rtt_xr_us;
    logic [31:0] rtt_base_us;
    logic [15:0] jitter_nominal_ms;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        done;
    logic [7:0]  loss_fraction;
    logic [7:0]  discard_fraction;
    logic [7:0]  burst_density;
    logic [7:0]  gap_density;
    logic [15:0] burst_duration_ms;
    logic [15:0] gap_duration_ms;
    logic [15:0] round_trip_ms;
    logic [15:0] end_system_delay_ms;

    report_tracker board;
    int unsigned   cycles;
    int unsigned   settings_used;

    voip_burst_gap_metrics_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .count_gap_gap       (count_gap_gap),
        .count_gap_burst_loss(count_gap_burst_loss),
        .count_gap_isolated  (count_gap_isolated),
        .count_burst_stay    (count_burst_stay),
        .count_burst_to_loss (count_burst_to_loss),
        .count_loss_loss     (count_loss_loss),
        .lost_packets        (lost_packets),
        .discarded_packets   (discarded_packets),
        .rtt_xr_us           (rtt_xr_us),
        .rtt_base_us         (rtt_base_us),
        .jitter_nominal_ms   (jitter_nominal_ms),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .done                (done),
        .loss_fraction       (loss_fraction),
        .discard_fraction    (discard_fraction),
        .burst_density       (burst_density),
        .gap_density         (gap_density),
        .burst_duration_ms   (burst_duration_ms),
        .gap_duration_ms     (gap_duration_ms),
        .round_trip_ms       (round_trip_ms),
        .end_system_delay_ms (end_system_delay_ms)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycles, board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Results cannot be held off: take every done strobe as it comes.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && done === 1'b1)
        begin
            got.loss_fraction       = loss_fraction;
            got.discard_fraction    = discard_fraction;
            got.burst_density       = burst_density;
            got.gap_density         = gap_density;
            got.burst_duration_ms   = burst_duration_ms;
            got.gap_duration_ms     = gap_duration_ms;
            got.round_trip_ms       = round_trip_ms;
            got.end_system_delay_ms = end_system_delay_ms;
            board.check_report(got);
        end
    end

    function automatic snapshot_t make_snapshot(
        logic [15:0] c11, logic [15:0] c13, logic [15:0] c14, logic [15:0] c22,
        logic [15:0] c23, logic [15:0] c33, logic [15:0] lost, logic [15:0] disc,
        logic [31:0] rtt_xr, logic [31:0] rtt_base, logic [15:0] jitter);
        snapshot_t s;
        s.c11 = c11;
        s.c13 = c13;
        s.c14 = c14;
        s.c22 = c22;
        s.c23 = c23;
        s.c33 = c33;
        s.lost = lost;
        s.disc = disc;
        s.rtt_xr = rtt_xr;
        s.rtt_base = rtt_base;
        s.jitter = jitter;
        return s;
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 15));
            4, 5:    return 16'($urandom_range(0, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_rtt();
        case ($urandom_range(0, 8))
            0, 1, 2: return 32'd0;
            3:       return 32'($urandom_range(1, 999));
            4, 5:    return 32'($urandom_range(1000, 2_000_000));
            6:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic snapshot_t random_snapshot();
        snapshot_t s;
        s.c11 = pick_count();
        s.c13 = pick_count();
        s.c14 = pick_count();
        s.c22 = pick_count();
        s.c23 = pick_count();
        s.c33 = pick_count();
        s.lost = pick_count();
        s.disc = pick_count();
        s.rtt_xr = pick_rtt();
        s.rtt_base = pick_rtt();
        s.jitter = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        // typical interval: mostly gap-state transitions, few losses
        if ($urandom_range(0, 3) == 0)
        begin
            s.c11 = 16'($urandom_range(1000, 65535));
            s.c13 = 16'($urandom_range(0, 50));
            s.c14 = 16'($urandom_range(0, 200));
            s.c22 = 16'($urandom_range(0, 100));
            s.c23 = 16'($urandom_range(0, 50));
            s.c33 = 16'($urandom_range(0, 100));
        end
        return s;
    endfunction

    // Called at a rising edge; leaves start high so a following transfer
    // can go back to back.
    task automatic send_snapshot(input snapshot_t s);
        count_gap_gap        <= s.c11;
        count_gap_burst_loss <= s.c13;
        count_gap_isolated   <= s.c14;
        count_burst_stay     <= s.c22;
        count_burst_to_loss  <= s.c23;
        count_loss_loss      <= s.c33;
        lost_packets         <= s.lost;
        discarded_packets    <= s.disc;
        rtt_xr_us            <= s.rtt_xr;
        rtt_base_us          <= s.rtt_base;
        jitter_nominal_ms    <= s.jitter;
        start                <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_snapshot(s);
    endtask

    task automatic wait_for_reports();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_registers(input logic [7:0] frame, input logic [4:0] fpp,
                                   input logic [9:0] extra);
        cfg_idx_t   order[3];
        logic [9:0] value[3];
        order[0] = CFG_EXTRA_DELAY;
        order[1] = CFG_FRAME_MS;
        order[2] = CFG_FRAMES_PKT;
        value[0] = extra;
        value[1] = {2'b00, frame};
        value[2] = {5'b00000, fpp};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= value[i];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            board.set_register(order[i], value[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        snapshot_t list[$];
        // all counts zero, no round trip yet
        list.push_back(make_snapshot(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // every field at its top value
        list.push_back(make_snapshot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 16'hFFFF));
        // zero gap-to-burst count
        list.push_back(make_snapshot(900, 0, 12, 30, 7, 15, 20, 4, 0, 0, 40));
        // zero gap-gap count: gap density drops to zero
        list.push_back(make_snapshot(0, 5, 17, 22, 9, 3, 11, 2, 0, 0, 60));
        // zero burst-to-loss count: burst density drops to zero
        list.push_back(make_snapshot(500, 8, 3, 40, 0, 6, 9, 1, 0, 0, 80));
        // burst density of 256 wraps to zero
        list.push_back(make_snapshot(100, 16'hFFFF, 5, 0, 1, 16'hFFFF, 3, 3, 0, 0, 10));
        // only the base estimate present
        list.push_back(make_snapshot(300, 4, 6, 10, 2, 8, 5, 5, 0, 48_500, 20));
        // both present: extended report wins
        list.push_back(make_snapshot(300, 4, 6, 10, 2, 8, 5, 5, 123_456, 48_500, 20));
        // neither present: hold the last round trip
        list.push_back(make_snapshot(300, 4, 6, 10, 2, 8, 5, 5, 0, 0, 20));
        // under one millisecond rounds the round trip down to zero
        list.push_back(make_snapshot(1, 1, 1, 1, 1, 1, 1, 1, 999, 0, 1));
        list.push_back(make_snapshot(1, 1, 1, 1, 1, 1, 1, 1, 0, 999, 1));
        // round trip at 16-bit top, delay sum wraps
        list.push_back(make_snapshot(2, 0, 0, 0, 0, 0, 0, 0, 65_535_999, 0, 16'hFFFF));
        // round trip past 16 bits wraps
        list.push_back(make_snapshot(2, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF));
        // losses far beyond the total: rates wrap in 8 bits
        list.push_back(make_snapshot(1, 0, 0, 0, 0, 0, 16'hFFFF, 16'hAAAA, 0, 0, 16'h5555));
        // single isolated-loss transition only
        list.push_back(make_snapshot(0, 0, 1, 0, 0, 0, 1, 0, 5000, 0, 0));
        // only burst-state counts
        list.push_back(make_snapshot(0, 0, 0, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555,
                                     16'hFFFF, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
        foreach (list[i])
            send_snapshot(list[i]);
        start <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input bit steady);
        int unsigned sent;
        int unsigned burst;
        int unsigned pause;
        bit          settle;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_snapshot(random_snapshot());
                sent++;
            end
            pause = 0;
            settle = 1'b0;
            if (!steady)
            begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3: pause = 0;
                    4, 5, 6:    pause = $urandom_range(1, 30);
                    default:    pause = $urandom_range(30, 400);
                endcase
                settle = ($urandom_range(0, 39) == 0);
            end
            if (pause != 0 || settle)
            begin
                start <= 1'b0;
                if (settle)
                    wait_for_reports();
                repeat (pause) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] frame;
        logic [4:0] fpp;
        logic [9:0] extra;
        board = new();
        cycles = 0;
        settings_used = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_MS;
        cfg_data = '0;
        count_gap_gap = '0;
        count_gap_burst_loss = '0;
        count_gap_isolated = '0;
        count_burst_stay = '0;
        count_burst_to_loss = '0;
        count_loss_loss = '0;
        lost_packets = '0;
        discarded_packets = '0;
        rtt_xr_us = '0;
        rtt_base_us = '0;
        jitter_nominal_ms = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values first
        run_directed();
        wait_for_reports();

        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p)
                0:       begin frame = 8'd255; fpp = 5'd31; extra = 10'd1023; end
                1:       begin frame = 8'd1;   fpp = 5'd1;  extra = 10'd0;    end
                2:       begin frame = 8'd0;   fpp = 5'd4;  extra = 10'd512;  end
                3:       begin frame = 8'd160; fpp = 5'd0;  extra = 10'd1;    end
                4:       begin frame = 8'd20;  fpp = 5'd16; extra = 10'd30;   end
                default:
                begin
                    frame = 8'($urandom_range(1, 255));
                    fpp = 5'($urandom_range(1, 16));
                    extra = 10'($urandom_range(0, 1023));
                end
            endcase
            write_registers(frame, fpp, extra);
            run_random(PhaseItems, p == 4);
            wait_for_reports();
        end

        repeat (TailCycles) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d reports never arrived", board.pending()));

        $display("Covered %0d snapshots under %0d register settings plus reset values;",
                 board.snapshots_taken, settings_used);
        $display("checked %0d reports, %0d mismatches.",
                 board.reports_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
